// ----- sv/text_console_writer_macros.svh -----
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam int CELL_W = 16;

    localparam logic [7:0] ATTR_RESET   = 8'h07;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_FILL,
        ST_CLEAR,
        ST_RESULT
    } tcw_state_t;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] read_char;
        logic [7:0] read_attr;
        logic       scrolled;
    } tcw_result_t;

endpackage

// ----- sv/tcw_cell_ram.sv -----
`timescale 1ns / 1ps

module tcw_cell_ram #(
    parameter int DEPTH = tcw_pkg::ROWS_DEF * tcw_pkg::COLS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [tcw_pkg::CELL_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tcw_ctrl.sv -----
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

module tcw_ctrl #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [7:0]                 text_attr,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [1:0]                 req_type,
    input  logic [7:0]                 char_code,
    input  logic [10:0]                cell_index,
    output logic                       res_valid,
    input  logic                       res_ready,
    output tcw_pkg::tcw_result_t       res,
    output logic                       mem_we,
    output logic [$clog2(ROWS*COLS)-1:0] mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0] mem_wdata,
    output logic                       mem_re,
    output logic [$clog2(ROWS*COLS)-1:0] mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0] mem_rdata
);

    localparam int NCELLS = ROWS * COLS;
    localparam int AW     = $clog2(NCELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);

    localparam logic [AW-1:0] LAST_ROW  = AW'(NCELLS - COLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(COLS);
    localparam logic [RW-1:0] ROW_MAX   = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_MAX   = CW'(COLS - 1);

    tcw_pkg::tcw_state_t state_reg, state_next;

    logic [1:0]    type_reg;
    logic [7:0]    char_reg;
    logic [10:0]   idx_reg;

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [AW-1:0] cell_reg, cell_next;
    logic [AW-1:0] walk_reg, walk_next;
    logic          scrolled_reg, scrolled_next;
    logic          rd_hit_reg, rd_hit_next;

    logic [tcw_pkg::CELL_W-1:0] blank;
    logic                       accept;
    logic                       idx_in_range;

    assign blank        = {text_attr, tcw_pkg::CH_SPACE};
    assign accept       = req_valid && !req_stall;
    assign idx_in_range = 32'(idx_reg) < NCELLS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tcw_pkg::ST_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            cell_reg     <= '0;
            walk_reg     <= '0;
            scrolled_reg <= 1'b0;
            rd_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            cell_reg     <= cell_next;
            walk_reg     <= walk_next;
            scrolled_reg <= scrolled_next;
            rd_hit_reg   <= rd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg <= req_type;
            char_reg <= char_code;
            idx_reg  <= cell_index;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cell_next     = cell_reg;
        walk_next     = walk_reg;
        scrolled_next = scrolled_reg;
        rd_hit_next   = rd_hit_reg;

        req_stall = 1'b1;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = cell_reg;
        mem_wdata = blank;
        mem_re    = 1'b0;
        mem_raddr = AW'(idx_reg);

        case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    scrolled_next = 1'b0;
                    rd_hit_next   = 1'b0;
                    state_next    = tcw_pkg::ST_EXEC;
                end
            end

            tcw_pkg::ST_EXEC:
            begin
                state_next = tcw_pkg::ST_RESULT;
                case (type_reg)
                    tcw_pkg::REQ_PUT:
                    begin
                        case (char_reg)
                            tcw_pkg::CH_NEWLINE:
                            begin
                                if (row_reg == ROW_MAX)
                                begin
                                    walk_next  = '0;
                                    state_next = tcw_pkg::ST_COPY;
                                end
                                else
                                begin
                                    row_next  = row_reg + RW'(1);
                                    col_next  = '0;
                                    cell_next = cell_reg - AW'(col_reg) + COLS_A;
                                end
                            end

                            tcw_pkg::CH_BACKSPACE:
                            begin
                                if (cell_reg != '0)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = cell_reg - AW'(1);
                                    cell_next = cell_reg - AW'(1);
                                    if (col_reg == '0)
                                    begin
                                        col_next = COL_MAX;
                                        row_next = row_reg - RW'(1);
                                    end
                                    else
                                    begin
                                        col_next = col_reg - CW'(1);
                                    end
                                end
                            end

                            default:
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {text_attr, char_reg};
                                if (col_reg != COL_MAX)
                                begin
                                    col_next  = col_reg + CW'(1);
                                    cell_next = cell_reg + AW'(1);
                                end
                                else if (row_reg != ROW_MAX)
                                begin
                                    col_next  = '0;
                                    row_next  = row_reg + RW'(1);
                                    cell_next = cell_reg + AW'(1);
                                end
                                else
                                begin
                                    walk_next  = '0;
                                    state_next = tcw_pkg::ST_COPY;
                                end
                            end
                        endcase
                    end

                    tcw_pkg::REQ_CLEAR:
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        cell_next  = '0;
                        walk_next  = '0;
                        state_next = tcw_pkg::ST_CLEAR;
                    end

                    tcw_pkg::REQ_READ:
                    begin
                        mem_re      = idx_in_range;
                        rd_hit_next = idx_in_range;
                    end

                    default:
                    begin
                        state_next = tcw_pkg::ST_RESULT;
                    end
                endcase

                // A scroll always leaves the cursor at the start of the last row.
                if (state_next == tcw_pkg::ST_COPY)
                begin
                    row_next      = ROW_MAX;
                    col_next      = '0;
                    cell_next     = LAST_ROW;
                    scrolled_next = 1'b1;
                end
            end

            tcw_pkg::ST_COPY:
            begin
                // Read one row ahead, write the cell read in the previous cycle.
                mem_re    = walk_reg != LAST_ROW;
                mem_raddr = walk_reg + COLS_A;
                mem_we    = walk_reg != '0;
                mem_waddr = walk_reg - AW'(1);
                mem_wdata = mem_rdata;
                if (walk_reg == LAST_ROW)
                begin
                    state_next = tcw_pkg::ST_FILL;
                end
                else
                begin
                    walk_next = walk_reg + AW'(1);
                end
            end

            tcw_pkg::ST_FILL, tcw_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = walk_reg;
                if (walk_reg == LAST_CELL)
                begin
                    state_next = tcw_pkg::ST_RESULT;
                end
                else
                begin
                    walk_next = walk_reg + AW'(1);
                end
            end

            tcw_pkg::ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.cursor_row = 5'(row_reg);
        res.cursor_col = 7'(col_reg);
        res.read_char  = rd_hit_reg ? mem_rdata[7:0] : 8'd0;
        res.read_attr  = rd_hit_reg ? mem_rdata[15:8] : 8'd0;
        res.scrolled   = scrolled_reg;
    end

    `TCW_ASSERT_IMPLY(a_cursor_consistent, clk, rst_n, 1'b1,
        int'(cell_reg) == int'(row_reg) * COLS + int'(col_reg), "cursor cell out of step")
    `TCW_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, accept,
        state_reg == tcw_pkg::ST_EXEC, "accepted item did not start")
    `TCW_ASSERT_IMPLY(a_write_in_range, clk, rst_n, mem_we,
        int'(mem_waddr) < NCELLS, "buffer write out of range")
    `TCW_ASSERT_IMPLY(a_no_same_cell, clk, rst_n, mem_we && mem_re,
        mem_waddr != mem_raddr, "read and write of one cell in one cycle")
    `TCW_ASSERT_IMPLY(a_scroll_cursor, clk, rst_n, res_valid && res.scrolled,
        row_reg == ROW_MAX && col_reg == '0, "scroll left cursor off the last row")

endmodule

// ----- sv/text_console_writer.sv -----
`timescale 1ns / 1ps
// A put, read or unused-type item passes ST_EXEC and ST_RESULT; then rsp_valid rises.
// Items are taken one at a time: req_stall stays high until the result is handed on.
// A scroll copies each row up one through the buffer RAM, then writes a blank last row.
// A clear writes a blank into every cell, one buffer RAM write per cell.
// Reset homes the cursor and sets text_attr to 7; the buffer is not cleared.
module text_console_writer #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_index,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic [7:0]  read_char,
    output logic [7:0]  read_attr,
    output logic        scrolled
);

    localparam int NCELLS = ROWS * COLS;
    localparam int AW     = $clog2(NCELLS);

    logic [7:0]                 attr_reg;
    logic                       rsp_valid_reg, rsp_valid_next;
    tcw_pkg::tcw_result_t       rsp_reg;

    logic                       res_valid;
    logic                       res_ready;
    tcw_pkg::tcw_result_t       res;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_rdata;

    // The output register frees up whenever its item is taken this cycle.
    assign res_ready      = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid_next = (res_valid && res_ready) || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= tcw_pkg::ATTR_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    tcw_ctrl #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_attr  (attr_reg),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .char_code  (char_code),
        .cell_index (cell_index),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    tcw_cell_ram #(
        .DEPTH (NCELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rsp_valid  = rsp_valid_reg;
    assign cursor_row = rsp_reg.cursor_row;
    assign cursor_col = rsp_reg.cursor_col;
    assign read_char  = rsp_reg.read_char;
    assign read_attr  = rsp_reg.read_attr;
    assign scrolled   = rsp_reg.scrolled;

endmodule
